// ===== sv/edf_pkg.sv =====
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types, codes and constants for the EDF task scheduler.
// ----------------------------------------------------------------------------
package edf_pkg;

    localparam int NUM_TASKS_DEF = 16;
    localparam int DEFAULT_DEADLINE = 5;
    localparam int CNT_W = 5;
    localparam int CNT_MAX = 31;

    typedef enum logic [2:0] {
        OP_SCHEDULE = 3'd0,
        OP_CREATE   = 3'd1,
        OP_SET_DL   = 3'd2,
        OP_SLEEP    = 3'd3,
        OP_PERIOD   = 3'd4,
        OP_YIELD    = 3'd5,
        OP_EXIT     = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_DORMANT  = 2'd0,
        ST_READY    = 2'd1,
        ST_RUNNING  = 2'd2,
        ST_SLEEPING = 2'd3
    } task_state_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  task_id;
        logic [15:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic       status;
        logic [3:0] assigned_task;
        logic [4:0] current_task;
        logic       switch_request;
    } res_item_t;

    typedef struct packed {
        task_state_t        state;
        logic signed [16:0] deadline;
        logic [15:0]        period;
        logic signed [16:0] sleep;
    } entry_t;

    function automatic entry_t reset_entry(input logic is_idle);
        entry_t e;
        e.state    = is_idle ? ST_READY : ST_DORMANT;
        e.deadline = 17'(DEFAULT_DEADLINE);
        e.period   = 16'(DEFAULT_DEADLINE);
        e.sleep    = '0;
        return e;
    endfunction

endpackage

// ===== sv/edf_mem.sv =====
// ----------------------------------------------------------------------------
// edf_mem
// Task table: one write port, one registered read port, per-entry valid bits.
// ----------------------------------------------------------------------------
module edf_mem #(
    parameter int NUM_TASKS = edf_pkg::NUM_TASKS_DEF,
    parameter int IW        = $clog2(NUM_TASKS)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  logic [IW-1:0]   rd_addr,
    output edf_pkg::entry_t rd_data,
    input  logic            wr_en,
    input  logic [IW-1:0]   wr_addr,
    input  edf_pkg::entry_t wr_data
);

    edf_pkg::entry_t mem [NUM_TASKS];
    logic [NUM_TASKS-1:0] valid_reg;
    edf_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr]
                                              : edf_pkg::reset_entry(rd_addr == '0);
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/edf_core.sv =====
// ----------------------------------------------------------------------------
// edf_core
// Event sequencer: reads, modifies and writes back task entries.
// ----------------------------------------------------------------------------
module edf_core #(
    parameter int NUM_TASKS = edf_pkg::NUM_TASKS_DEF,
    parameter int IW        = $clog2(NUM_TASKS),
    parameter int TW        = $clog2(NUM_TASKS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  edf_pkg::cmd_item_t cmd,
    output logic               idle,
    output logic               done,
    output edf_pkg::res_item_t result,
    input  logic               take,
    output logic               rd_en,
    output logic [IW-1:0]      rd_addr,
    input  edf_pkg::entry_t    rd_data,
    output logic               wr_en,
    output logic [IW-1:0]      wr_addr,
    output edf_pkg::entry_t    wr_data
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b00000000001,
        S_RD_CUR    = 11'b00000000010,
        S_CUR_DATA  = 11'b00000000100,
        S_TID_DATA  = 11'b00000001000,
        S_FIND      = 11'b00000010000,
        S_SCAN_INIT = 11'b00000100000,
        S_SCAN      = 11'b00001000000,
        S_SCAN_END  = 11'b00010000000,
        S_DSP_OLD   = 11'b00100000000,
        S_DSP_NEW   = 11'b01000000000,
        S_DONE      = 11'b10000000000
    } fsm_t;

    localparam logic [TW-1:0] NONE = TW'(NUM_TASKS);
    localparam logic [IW-1:0] LAST = IW'(NUM_TASKS - 1);

    fsm_t state_reg, state_next;
    edf_pkg::op_t op_reg, op_next;
    logic [3:0] tid_reg, tid_next;
    logic [15:0] val_reg, val_next;
    logic [TW-1:0] cur_reg, cur_next;
    logic [TW-1:0] nxt_reg, nxt_next;
    logic [edf_pkg::CNT_W-1:0] sleepers_reg, sleepers_next;
    logic [edf_pkg::CNT_W-1:0] live_reg, live_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic signed [17:0] best_reg, best_next;
    logic best_far_reg, best_far_next;
    edf_pkg::entry_t cur_ent_reg, cur_ent_next;
    logic reload_reg, reload_next;
    logic err_reg, err_next;
    logic sw_reg, sw_next;
    logic [3:0] asg_reg, asg_next;

    logic cur_in;
    logic [IW-1:0] cur_idx;
    logic [IW-1:0] tid_idx;
    logic signed [17:0] val_s;
    logic signed [17:0] cur_dl;
    logic signed [17:0] dec;
    logic pick;
    edf_pkg::entry_t ent;

    assign cur_in  = cur_reg < NONE;
    assign cur_idx = cur_reg[IW-1:0];
    assign tid_idx = IW'(tid_reg);
    assign val_s   = 18'(val_reg) & 18'h0FFFF;
    assign cur_dl  = 18'(cur_ent_reg.deadline);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        tid_next      = tid_reg;
        val_next      = val_reg;
        cur_next      = cur_reg;
        nxt_next      = nxt_reg;
        sleepers_next = sleepers_reg;
        live_next     = live_reg;
        idx_next      = idx_reg;
        best_next     = best_reg;
        best_far_next = best_far_reg;
        reload_next   = reload_reg;
        err_next      = err_reg;
        sw_next       = sw_reg;
        asg_next      = asg_reg;
        rd_en         = 1'b0;
        rd_addr       = cur_idx;
        wr_en         = 1'b0;
        wr_addr       = cur_idx;
        wr_data       = rd_data;
        ent           = rd_data;
        dec           = '0;
        pick          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = edf_pkg::op_t'(cmd.operation);
                    tid_next    = cmd.task_id;
                    val_next    = cmd.value;
                    err_next    = 1'b0;
                    sw_next     = 1'b0;
                    asg_next    = '0;
                    reload_next = 1'b0;
                    state_next  = S_RD_CUR;
                end
            end
            S_RD_CUR:
            begin
                rd_en      = cur_in;
                rd_addr    = cur_idx;
                state_next = S_CUR_DATA;
            end
            S_CUR_DATA:
            begin
                ent = rd_data;
                unique case (op_reg) inside
                    edf_pkg::OP_SCHEDULE:
                    begin
                        state_next = S_SCAN_INIT;
                    end
                    edf_pkg::OP_CREATE:
                    begin
                        if (val_reg == '0)
                        begin
                            err_next   = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = IW'(1);
                            idx_next   = IW'(1);
                            state_next = S_FIND;
                        end
                    end
                    edf_pkg::OP_SET_DL:
                    begin
                        if (val_reg == '0 || tid_reg == '0 || int'(tid_reg) >= NUM_TASKS
                            || TW'(tid_reg) == cur_reg)
                        begin
                            err_next   = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = tid_idx;
                            state_next = S_TID_DATA;
                        end
                    end
                    edf_pkg::OP_SLEEP, edf_pkg::OP_PERIOD, edf_pkg::OP_EXIT:
                    begin
                        if (!cur_in || ent.state != edf_pkg::ST_RUNNING || cur_reg == '0)
                        begin
                            err_next   = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = cur_idx;
                            wr_data = ent;
                            if (op_reg == edf_pkg::OP_EXIT)
                            begin
                                wr_data.state = edf_pkg::ST_DORMANT;
                                if (live_reg != '0)
                                begin
                                    live_next = live_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                wr_data.state = edf_pkg::ST_SLEEPING;
                                wr_data.sleep = (op_reg == edf_pkg::OP_SLEEP)
                                                ? 17'(val_s) : ent.deadline;
                                if (sleepers_reg != edf_pkg::CNT_W'(edf_pkg::CNT_MAX))
                                begin
                                    sleepers_next = sleepers_reg + 1'b1;
                                end
                            end
                            state_next = S_SCAN_INIT;
                        end
                    end
                    edf_pkg::OP_YIELD:
                    begin
                        if (!cur_in || ent.state != edf_pkg::ST_RUNNING)
                        begin
                            err_next   = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            wr_addr          = cur_idx;
                            wr_data          = ent;
                            wr_data.deadline = 17'(ent.period);
                            state_next       = S_SCAN_INIT;
                        end
                    end
                    default:
                    begin
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_TID_DATA:
            begin
                if (rd_data.state != edf_pkg::ST_READY)
                begin
                    err_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    wr_en            = 1'b1;
                    wr_addr          = tid_idx;
                    wr_data          = rd_data;
                    wr_data.deadline = 17'(val_s);
                    wr_data.period   = val_reg;
                    if (!cur_in || val_s < cur_dl)
                    begin
                        reload_next = 1'b1;
                        nxt_next    = TW'(tid_reg);
                        state_next  = S_DSP_OLD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_FIND:
            begin
                if (rd_data.state == edf_pkg::ST_DORMANT)
                begin
                    wr_en            = 1'b1;
                    wr_addr          = idx_reg;
                    wr_data          = rd_data;
                    wr_data.state    = edf_pkg::ST_READY;
                    wr_data.deadline = 17'(val_s);
                    wr_data.period   = val_reg;
                    asg_next         = 4'(idx_reg);
                    if (live_reg != edf_pkg::CNT_W'(edf_pkg::CNT_MAX))
                    begin
                        live_next = live_reg + 1'b1;
                    end
                    if (TW'(idx_reg) != cur_reg
                        && (!cur_in || val_s < cur_dl
                            || (val_s == cur_dl && TW'(idx_reg) < cur_reg)))
                    begin
                        nxt_next   = TW'(idx_reg);
                        state_next = S_DSP_OLD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (idx_reg == LAST)
                begin
                    err_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                end
            end
            S_SCAN_INIT:
            begin
                if (cur_in && sleepers_reg != live_reg)
                begin
                    nxt_next = cur_reg;
                end
                else
                begin
                    nxt_next = '0;
                end
                best_far_next = !cur_in || cur_ent_reg.state == edf_pkg::ST_SLEEPING
                                || cur_ent_reg.state == edf_pkg::ST_DORMANT;
                best_next     = cur_dl;
                rd_en         = 1'b1;
                rd_addr       = IW'(1);
                idx_next      = IW'(1);
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                ent = rd_data;
                if (rd_data.state == edf_pkg::ST_SLEEPING)
                begin
                    dec       = 18'(rd_data.sleep) - 18'sd1;
                    ent.sleep = dec[16:0];
                    if (dec < 0)
                    begin
                        ent.state    = edf_pkg::ST_READY;
                        ent.deadline = 17'(rd_data.period);
                        if (sleepers_reg != '0)
                        begin
                            sleepers_next = sleepers_reg - 1'b1;
                        end
                    end
                end
                else if (rd_data.state != edf_pkg::ST_DORMANT)
                begin
                    dec  = 18'(rd_data.deadline) - 18'sd1;
                    pick = best_far_reg || dec < best_reg
                           || (dec == best_reg && TW'(idx_reg) <= nxt_reg);
                    if (pick)
                    begin
                        best_next     = dec;
                        best_far_next = 1'b0;
                        nxt_next      = TW'(idx_reg);
                    end
                    ent.deadline = (dec < 0) ? 17'(rd_data.period) : dec[16:0];
                end
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = ent;
                if (idx_reg == LAST)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SCAN_END:
            begin
                state_next = (nxt_reg != cur_reg) ? S_DSP_OLD : S_DONE;
            end
            S_DSP_OLD:
            begin
                wr_en   = cur_in;
                wr_addr = cur_idx;
                wr_data = cur_ent_reg;
                if (cur_ent_reg.state == edf_pkg::ST_READY
                    || cur_ent_reg.state == edf_pkg::ST_RUNNING)
                begin
                    wr_data.state = edf_pkg::ST_READY;
                end
                if (reload_reg)
                begin
                    wr_data.deadline = 17'(cur_ent_reg.period);
                end
                rd_en      = 1'b1;
                rd_addr    = nxt_reg[IW-1:0];
                state_next = S_DSP_NEW;
            end
            S_DSP_NEW:
            begin
                wr_en         = 1'b1;
                wr_addr       = nxt_reg[IW-1:0];
                wr_data       = rd_data;
                wr_data.state = edf_pkg::ST_RUNNING;
                cur_next      = nxt_reg;
                sw_next       = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (wr_en && TW'(wr_addr) == cur_reg)
        begin
            cur_ent_next = wr_data;
        end
        else if (state_reg == S_CUR_DATA)
        begin
            cur_ent_next = rd_data;
        end
        else if (state_reg == S_DSP_NEW)
        begin
            cur_ent_next = rd_data;
            cur_ent_next.state = edf_pkg::ST_RUNNING;
        end
        else
        begin
            cur_ent_next = cur_ent_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cur_reg      <= NONE;
            sleepers_reg <= '0;
            live_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            sleepers_reg <= sleepers_next;
            live_reg     <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        tid_reg      <= tid_next;
        val_reg      <= val_next;
        nxt_reg      <= nxt_next;
        idx_reg      <= idx_next;
        best_reg     <= best_next;
        best_far_reg <= best_far_next;
        cur_ent_reg  <= cur_ent_next;
        reload_reg   <= reload_next;
        err_reg      <= err_next;
        sw_reg       <= sw_next;
        asg_reg      <= asg_next;
    end

    assign idle                  = state_reg == S_IDLE;
    assign done                  = state_reg == S_DONE;
    assign result.status         = err_reg;
    assign result.assigned_task  = err_reg ? 4'd0 : asg_reg;
    assign result.current_task   = 5'(cur_reg);
    assign result.switch_request = sw_reg;

endmodule

// ===== sv/edf_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// edf_task_scheduler
// Earliest-deadline-first scheduler over a task table held in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one event item: operation,
//   task_id and value. res channel (res_valid/res_ready/res) returns exactly
//   one item per event: status, assigned_task, current_task, switch_request.
//   One event is handled at a time. Schedule, sleep, period, yield and exit
//   walk the whole task table, create probes slots for a dormant one, and
//   set deadline and create switch tasks when the new deadline preempts;
//   a switch adds the states S_DSP_OLD and S_DSP_NEW. An error found on
//   the running entry or an unused code ends the event with no table walk.
//   The walk over the task table passes through the table's single
//   read port, one entry per cycle. cmd_ready rises at the edge that loads
//   the result into the output register, so a held result blocks only
//   the completion of the following event, not its acceptance.
//   Reset leaves slot 0 ready, all other slots dormant, deadlines 5, no task
//   running and the output register empty.
// ----------------------------------------------------------------------------
module edf_task_scheduler #(
    parameter int NUM_TASKS = edf_pkg::NUM_TASKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  edf_pkg::cmd_item_t cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output edf_pkg::res_item_t res
);

    localparam int IW = $clog2(NUM_TASKS);
    localparam int TW = $clog2(NUM_TASKS + 1);

    logic               idle;
    logic               done;
    logic               take;
    edf_pkg::res_item_t result;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    edf_pkg::entry_t    rd_data;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    edf_pkg::entry_t    wr_data;
    logic               res_valid_reg;
    edf_pkg::res_item_t res_reg;

    assign cmd_ready = idle;
    assign take      = done && (!res_valid_reg || res_ready);

    edf_core #(
        .NUM_TASKS(NUM_TASKS),
        .IW(IW),
        .TW(TW)
    ) u_core (
        .clk(clk),
        .rst_n(rst_n),
        .start(cmd_valid && idle),
        .cmd(cmd),
        .idle(idle),
        .done(done),
        .result(result),
        .take(take),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    edf_mem #(
        .NUM_TASKS(NUM_TASKS),
        .IW(IW)
    ) u_mem (
        .clk(clk),
        .rst_n(rst_n),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== sv/edf_checker.sv =====
// ----------------------------------------------------------------------------
// edf_checker
// Port-level checks on the scheduler's command and result channels.
// ----------------------------------------------------------------------------
module edf_checker #(
    parameter int NUM_TASKS = edf_pkg::NUM_TASKS_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic               res_valid,
    input logic               res_ready,
    input edf_pkg::res_item_t res
);

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("held result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status |-> !res.switch_request && res.assigned_task == 4'd0)
        else $error("failed event reports a switch or a slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.switch_request |-> res.current_task != 5'(NUM_TASKS))
        else $error("switch to no task");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("second item taken while busy");

endmodule

bind edf_task_scheduler edf_checker #(.NUM_TASKS(NUM_TASKS)) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
);
